// ----- src/bbc_pkg.sv -----
// Shared types and codes for the block buffer cache.
package bbc_pkg;

    localparam int ACTION_W = 2;
    localparam int DEVICE_W = 8;
    localparam int BLOCK_W  = 24;
    localparam int ENTRY_W  = 5;
    localparam int TICK_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_GET     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIN     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNPIN   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                valid;
        logic [DEVICE_W-1:0] dev;
        logic [BLOCK_W-1:0]  blk;
        logic [COUNT_W-1:0]  cnt;
        logic [TICK_W-1:0]   tick;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic clear_step;
        logic scan_step;
        logic op_read;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic req_get;
        logic req_bad;
        logic out_free;
    } sts_t;

endpackage

// ----- src/bbc_req_if.sv -----
// Request channel: one cache action per item.
interface bbc_req_if;
    logic                            valid;
    logic                            ready;
    logic [bbc_pkg::ACTION_W-1:0]    action;
    logic [bbc_pkg::DEVICE_W-1:0]    device;
    logic [bbc_pkg::BLOCK_W-1:0]     block_number;
    logic [bbc_pkg::ENTRY_W-1:0]     entry_index;
    logic [bbc_pkg::TICK_W-1:0]      now_tick;

    modport source (output valid, action, device, block_number, entry_index, now_tick,
                    input ready);
    modport sink   (input valid, action, device, block_number, entry_index, now_tick,
                    output ready);
endinterface

// ----- src/bbc_rsp_if.sv -----
// Response channel: one result per request item.
interface bbc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bbc_pkg::ENTRY_W-1:0]     result_entry;
    logic                            hit;
    logic                            need_disk_read;
    logic [bbc_pkg::STATUS_W-1:0]    status;

    modport source (output valid, result_entry, hit, need_disk_read, status,
                    input ready);
    modport sink   (input valid, result_entry, hit, need_disk_read, status,
                    output ready);
endinterface

// ----- src/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/bbc_ctrl.sv -----
// Sequencer for clear pass, table scan, entry read and result hand-off.
module bbc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bbc_pkg::sts_t sts,
    output bbc_pkg::cmd_t cmd
);
    import bbc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_OPRD  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.req_get)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (sts.req_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OPRD;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_OPRD:
            begin
                cmd.op_read = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("request accepted during clear pass");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
`endif

endmodule

// ----- src/bbc_dpath.sv -----
// Entry table, scan compare logic, update logic and result register.
module bbc_dpath #(
    parameter int ENTRIES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bbc_pkg::ACTION_W-1:0]  action,
    input  logic [bbc_pkg::DEVICE_W-1:0]  device,
    input  logic [bbc_pkg::BLOCK_W-1:0]   block_number,
    input  logic [bbc_pkg::ENTRY_W-1:0]   entry_index,
    input  logic [bbc_pkg::TICK_W-1:0]    now_tick,
    input  bbc_pkg::cmd_t                 cmd,
    output bbc_pkg::sts_t                 sts,
    bbc_rsp_if.source                     rsp
);
    import bbc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // request latch
    logic [ACTION_W-1:0] action_reg;
    logic [DEVICE_W-1:0] dev_reg;
    logic [BLOCK_W-1:0]  blk_reg;
    logic [ENTRY_W-1:0]  idx_reg;
    logic [TICK_W-1:0]   now_reg;
    logic                bad_reg;

    // scan state
    logic [IDX_W-1:0]    addr_reg;
    logic                eval_v_reg;
    logic [IDX_W-1:0]    eval_addr_reg;
    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    entry_t              match_word_reg;
    logic                victim_found_reg;
    logic [IDX_W-1:0]    victim_idx_reg;
    logic [TICK_W-1:0]   victim_tick_reg;

    // result register
    logic                out_valid_reg;
    logic [ENTRY_W-1:0]  out_entry_reg;
    logic                out_hit_reg;
    logic                out_rd_reg;
    logic [STATUS_W-1:0] out_status_reg;

    entry_t              rd_word;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                req_bad;
    logic                scan_match;
    logic                scan_victim;
    logic [IDX_W-1:0]    op_addr;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_BITS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;

    entry_t              upd_word;
    logic                upd_we;
    logic [IDX_W-1:0]    upd_addr;
    logic [ENTRY_W-1:0]  res_entry;
    logic                res_hit;
    logic                res_rd;
    logic [STATUS_W-1:0] res_status;

    assign rd_word = entry_t'(rd_data);
    assign req_bad = 32'(entry_index) >= ENTRIES;
    assign op_addr = IDX_W'(idx_reg);

    assign sts.last     = (addr_reg == LAST_IDX);
    assign sts.req_get  = (action == ACT_GET);
    assign sts.req_bad  = req_bad;
    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign scan_match  = eval_v_reg && (rd_word.dev == dev_reg) && (rd_word.blk == blk_reg);
    assign scan_victim = eval_v_reg && (rd_word.cnt == '0) &&
                         (!victim_found_reg || (rd_word.tick < victim_tick_reg));

    assign ram_rd_en   = cmd.scan_step || cmd.op_read;
    assign ram_rd_addr = cmd.op_read ? op_addr : addr_reg;
    assign ram_we      = cmd.clear_step || (cmd.finish && upd_we);
    assign ram_wr_addr = cmd.clear_step ? addr_reg : upd_addr;
    assign ram_wr_data = cmd.clear_step ? '0 : ENTRY_BITS'(upd_word);

    bbc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    // result and write-back for the finishing item
    always_comb
    begin
        upd_word   = rd_word;
        upd_we     = 1'b0;
        upd_addr   = op_addr;
        res_entry  = idx_reg;
        res_hit    = 1'b0;
        res_rd     = 1'b0;
        res_status = ST_OK;
        if (action_reg == ACT_GET)
        begin
            if (match_found_reg)
            begin
                upd_word       = match_word_reg;
                upd_word.valid = 1'b1;
                if (match_word_reg.cnt != COUNT_MAX)
                begin
                    upd_word.cnt = match_word_reg.cnt + COUNT_W'(1);
                end
                upd_we    = 1'b1;
                upd_addr  = match_idx_reg;
                res_entry = ENTRY_W'(match_idx_reg);
                res_hit   = 1'b1;
                res_rd    = !match_word_reg.valid;
            end
            else if (victim_found_reg)
            begin
                upd_word.valid = 1'b1;
                upd_word.dev   = dev_reg;
                upd_word.blk   = blk_reg;
                upd_word.cnt   = COUNT_W'(1);
                upd_word.tick  = victim_tick_reg;
                upd_we    = 1'b1;
                upd_addr  = victim_idx_reg;
                res_entry = ENTRY_W'(victim_idx_reg);
                res_rd    = 1'b1;
            end
            else
            begin
                res_entry  = '0;
                res_status = ST_NOFREE;
            end
        end
        else if (bad_reg)
        begin
            res_status = ST_BADIDX;
        end
        else if (action_reg == ACT_PIN)
        begin
            if (rd_word.cnt != COUNT_MAX)
            begin
                upd_word.cnt = rd_word.cnt + COUNT_W'(1);
            end
            upd_we = 1'b1;
        end
        else if (rd_word.cnt == '0)
        begin
            res_status = ST_UNDER;
        end
        else
        begin
            upd_word.cnt = rd_word.cnt - COUNT_W'(1);
            if ((action_reg == ACT_RELEASE) && (rd_word.cnt == COUNT_W'(1)))
            begin
                upd_word.tick = now_reg;
            end
            upd_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            dev_reg    <= device;
            blk_reg    <= block_number;
            idx_reg    <= entry_index;
            now_reg    <= now_tick;
            bad_reg    <= req_bad;
        end
        eval_addr_reg <= addr_reg;
        if (scan_match && !match_found_reg)
        begin
            match_idx_reg  <= eval_addr_reg;
            match_word_reg <= rd_word;
        end
        if (scan_victim)
        begin
            victim_idx_reg  <= eval_addr_reg;
            victim_tick_reg <= rd_word.tick;
        end
        if (cmd.finish)
        begin
            out_entry_reg  <= res_entry;
            out_hit_reg    <= res_hit;
            out_rd_reg     <= res_rd;
            out_status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg         <= '0;
            eval_v_reg       <= 1'b0;
            match_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            eval_v_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                addr_reg <= '0;
            end
            else if (cmd.clear_step || cmd.scan_step)
            begin
                addr_reg <= sts.last ? '0 : addr_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                match_found_reg  <= 1'b0;
                victim_found_reg <= 1'b0;
            end
            else
            begin
                if (scan_match)
                begin
                    match_found_reg <= 1'b1;
                end
                if (scan_victim)
                begin
                    victim_found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_entry   = out_entry_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.need_disk_read = out_rd_reg;
    assign rsp.status         = out_status_reg;

`ifndef SYNTHESIS
    a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.status == ST_OK))
        else $error("hit reported with error status");
    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished item not presented");
    a_load_clears_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!match_found_reg && !victim_found_reg))
        else $error("search flags not cleared on new item");
`endif

endmodule

// ----- src/block_buffer_cache_lru_unit.sv -----
// Top level of the block buffer cache with reference counts and LRU reuse.
//
//   channel  role   handshake     payload
//   req      sink   valid/ready   action, device, block_number, entry_index, now_tick
//   rsp      source valid/ready   result_entry, hit, need_disk_read, status
//
// Get: a scan of every entry; the table RAM is read one entry per cycle by one port.
// Release, pin, unpin: one RAM read, then write-back; bad index: no table access.
// After reset a clearing pass writes every entry with req.ready low.
// One item in flight; a finished result waits in the output register while the next
// item is taken, and only the write-back stalls on a full output register.
module block_buffer_cache_lru_unit #(
    parameter int ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bbc_req_if.sink   req,
    bbc_rsp_if.source rsp
);
    import bbc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bbc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (req.action),
        .device       (req.device),
        .block_number (req.block_number),
        .entry_index  (req.entry_index),
        .now_tick     (req.now_tick),
        .cmd          (cmd),
        .sts          (sts),
        .rsp          (rsp)
    );

endmodule
